FILE: design/flight_safety_envelope_monitor_top_assert.svh
// Assertion macros shared by the monitor's checking code.
`ifndef FLIGHT_SAFETY_ENVELOPE_MONITOR_TOP_ASSERT_SVH
`define FLIGHT_SAFETY_ENVELOPE_MONITOR_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define FSEM_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define FSEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/fsem_pkg.sv
package fsem_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_TILT_COS  = 3'd0;
  localparam logic [2:0] REG_SPEED     = 3'd1;
  localparam logic [2:0] REG_ALT       = 3'd2;
  localparam logic [2:0] REG_POS_ERR   = 3'd3;
  localparam logic [2:0] REG_OSC_WIN   = 3'd4;
  localparam logic [2:0] REG_OSC_MIN   = 3'd5;
  localparam logic [2:0] REG_OSC_RMS   = 3'd6;
  localparam logic [2:0] REG_STALE     = 3'd7;

  // Item kinds on in_tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_STALE  = 1'b1;

  // Squarer operand selects; lane-indexed selects use the lane field.
  localparam logic [2:0] SQ_QX  = 3'd0;
  localparam logic [2:0] SQ_QY  = 3'd1;
  localparam logic [2:0] SQ_V   = 3'd2;
  localparam logic [2:0] SQ_D   = 3'd3;
  localparam logic [2:0] SQ_SPD = 3'd4;
  localparam logic [2:0] SQ_PEL = 3'd5;
  localparam logic [2:0] SQ_IR  = 3'd6;
  localparam logic [2:0] SQ_RR  = 3'd7;

  // Datapath operations.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_ACC_LOAD = 4'd1;
  localparam logic [3:0] OP_ACC_ADD  = 4'd2;
  localparam logic [3:0] OP_TILT     = 4'd3;
  localparam logic [3:0] OP_CMP_SPD  = 4'd4;
  localparam logic [3:0] OP_CMP_POS  = 4'd5;
  localparam logic [3:0] OP_STALE    = 4'd6;
  localparam logic [3:0] OP_EVICT    = 4'd7;
  localparam logic [3:0] OP_INSERT   = 4'd8;

  // Serial multiplier jobs, issued in this order.
  localparam logic [3:0] MS_NQX  = 4'd0;
  localparam logic [3:0] MS_SX   = 4'd1;
  localparam logic [3:0] MS_NQY  = 4'd2;
  localparam logic [3:0] MS_SY   = 4'd3;
  localparam logic [3:0] MS_NQZ  = 4'd4;
  localparam logic [3:0] MS_SZ   = 4'd5;
  localparam logic [3:0] MS_LRPN = 4'd6;
  localparam logic [3:0] MS_LRPQ = 4'd7;
  localparam logic [3:0] MS_LYWN = 4'd8;
  localparam logic [3:0] MS_LYWQ = 4'd9;

  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;

  typedef struct packed {
    logic       latch;
    logic [2:0] sq_sel;
    logic [1:0] lane;
    logic [3:0] op;
    logic       mul_start;
    logic [3:0] msel;
    logic       load_out;
  } fsem_cmd_t;

  typedef struct packed {
    logic win_full;
    logic win_empty;
    logic age_over;
    logic osc_en;
    logic mul_busy;
  } fsem_sts_t;

  function automatic logic signed [15:0] lane16(input logic [47:0] w, input logic [1:0] k);
    logic signed [15:0] r;
    case (k)
      LANE_X:  r = w[15:0];
      LANE_Y:  r = w[31:16];
      default: r = w[47:32];
    endcase
    return r;
  endfunction

endpackage

FILE: design/fsem_ram.sv
module fsem_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

FILE: design/fsem_ctrl.sv
module fsem_ctrl
  import fsem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_kind,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  fsem_sts_t sts,
  output fsem_cmd_t cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_STALE = 5'd1;
  localparam logic [4:0] S_T0    = 5'd2;
  localparam logic [4:0] S_T1    = 5'd3;
  localparam logic [4:0] S_V0    = 5'd4;
  localparam logic [4:0] S_V1    = 5'd5;
  localparam logic [4:0] S_V2    = 5'd6;
  localparam logic [4:0] S_V3    = 5'd7;
  localparam logic [4:0] S_P0    = 5'd8;
  localparam logic [4:0] S_P1    = 5'd9;
  localparam logic [4:0] S_P2    = 5'd10;
  localparam logic [4:0] S_P3    = 5'd11;
  localparam logic [4:0] S_FULL  = 5'd12;
  localparam logic [4:0] S_ERD   = 5'd13;
  localparam logic [4:0] S_ECHK  = 5'd14;
  localparam logic [4:0] S_E0    = 5'd15;
  localparam logic [4:0] S_E1    = 5'd16;
  localparam logic [4:0] S_E2    = 5'd17;
  localparam logic [4:0] S_A0    = 5'd18;
  localparam logic [4:0] S_A1    = 5'd19;
  localparam logic [4:0] S_A2    = 5'd20;
  localparam logic [4:0] S_OSC   = 5'd21;
  localparam logic [4:0] S_MST   = 5'd22;
  localparam logic [4:0] S_MW    = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic       full_evict_r, full_evict_nxt;
  logic [3:0] msel_r, msel_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    full_evict_nxt = full_evict_r;
    msel_nxt       = msel_r;
    cmd            = '0;
    cmd.msel       = msel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = (in_kind == CMD_STALE) ? S_STALE : S_T0;
        end
      end
      S_STALE: begin
        cmd.op    = OP_STALE;
        state_nxt = S_OUT;
      end
      S_T0: begin
        cmd.sq_sel = SQ_QX;
        cmd.op     = OP_ACC_LOAD;
        state_nxt  = S_T1;
      end
      S_T1: begin
        cmd.sq_sel = SQ_QY;
        cmd.op     = OP_TILT;
        state_nxt  = S_V0;
      end
      S_V0: begin
        cmd.sq_sel = SQ_V;
        cmd.lane   = LANE_X;
        cmd.op     = OP_ACC_LOAD;
        state_nxt  = S_V1;
      end
      S_V1: begin
        cmd.sq_sel = SQ_V;
        cmd.lane   = LANE_Y;
        cmd.op     = OP_ACC_ADD;
        state_nxt  = S_V2;
      end
      S_V2: begin
        cmd.sq_sel = SQ_V;
        cmd.lane   = LANE_Z;
        cmd.op     = OP_ACC_ADD;
        state_nxt  = S_V3;
      end
      S_V3: begin
        cmd.sq_sel = SQ_SPD;
        cmd.op     = OP_CMP_SPD;
        state_nxt  = S_P0;
      end
      S_P0: begin
        cmd.sq_sel = SQ_D;
        cmd.lane   = LANE_X;
        cmd.op     = OP_ACC_LOAD;
        state_nxt  = S_P1;
      end
      S_P1: begin
        cmd.sq_sel = SQ_D;
        cmd.lane   = LANE_Y;
        cmd.op     = OP_ACC_ADD;
        state_nxt  = S_P2;
      end
      S_P2: begin
        cmd.sq_sel = SQ_D;
        cmd.lane   = LANE_Z;
        cmd.op     = OP_ACC_ADD;
        state_nxt  = S_P3;
      end
      S_P3: begin
        cmd.sq_sel = SQ_PEL;
        cmd.op     = OP_CMP_POS;
        state_nxt  = S_FULL;
      end
      S_FULL: begin
        if (sts.win_full) begin
          full_evict_nxt = 1'b1;
          state_nxt      = S_ERD;
        end else begin
          state_nxt = S_A0;
        end
      end
      // The memory reads the oldest slot every cycle; this state lets it settle.
      S_ERD: state_nxt = S_ECHK;
      S_ECHK: begin
        if (full_evict_r || (!sts.win_empty && sts.age_over)) begin
          state_nxt = S_E0;
        end else begin
          state_nxt = S_OSC;
        end
      end
      S_E0: begin
        cmd.sq_sel = SQ_RR;
        cmd.lane   = LANE_X;
        cmd.op     = OP_EVICT;
        state_nxt  = S_E1;
      end
      S_E1: begin
        cmd.sq_sel = SQ_RR;
        cmd.lane   = LANE_Y;
        cmd.op     = OP_EVICT;
        state_nxt  = S_E2;
      end
      S_E2: begin
        cmd.sq_sel = SQ_RR;
        cmd.lane   = LANE_Z;
        cmd.op     = OP_EVICT;
        state_nxt  = full_evict_r ? S_A0 : S_ERD;
      end
      S_A0: begin
        cmd.sq_sel     = SQ_IR;
        cmd.lane       = LANE_X;
        cmd.op         = OP_INSERT;
        full_evict_nxt = 1'b0;
        state_nxt      = S_A1;
      end
      S_A1: begin
        cmd.sq_sel = SQ_IR;
        cmd.lane   = LANE_Y;
        cmd.op     = OP_INSERT;
        state_nxt  = S_A2;
      end
      S_A2: begin
        cmd.sq_sel = SQ_IR;
        cmd.lane   = LANE_Z;
        cmd.op     = OP_INSERT;
        state_nxt  = S_ERD;
      end
      S_OSC: begin
        msel_nxt  = MS_NQX;
        state_nxt = sts.osc_en ? S_MST : S_OUT;
      end
      S_MST: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MW;
      end
      S_MW: begin
        if (!sts.mul_busy) begin
          if (msel_r == MS_LYWQ) begin
            state_nxt = S_OUT;
          end else begin
            msel_nxt  = msel_r + 4'd1;
            state_nxt = S_MST;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      full_evict_r <= 1'b0;
      msel_r       <= MS_NQX;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      full_evict_r <= full_evict_nxt;
      msel_r       <= msel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

FILE: design/fsem_datapath.sv
module fsem_datapath
  import fsem_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [263:0] in_tdata,
  input  fsem_cmd_t   cmd,
  output fsem_sts_t   sts,
  output logic [7:0]  out_flags_r
);

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int EW  = (CW > 7) ? CW : 7;
  localparam int SW  = 16 + CW;
  localparam int SQW = 30 + CW;
  localparam int VW  = 33 + 2 * CW;
  localparam int MA  = 30 + CW;
  localparam int MB  = 16 + CW;
  localparam int PW  = MA + MB;
  localparam int RW  = 80;

  // Configuration.
  logic signed [15:0] tilt_cos_r;
  logic [15:0]        speed_lim_r;
  logic [31:0]        alt_bounds_r;
  logic [15:0]        pos_err_lim_r;
  logic [31:0]        osc_window_r;
  logic [6:0]         osc_min_r;
  logic [31:0]        osc_rms_r;
  logic [31:0]        stale_to_r;

  // Latched item.
  logic [31:0] t_r, quat_r;
  logic [47:0] vel_r, pos_r, tgt_r, rates_r;
  logic        tv_r, mae_r;

  // Window state.
  logic [AW-1:0]        head_r;
  logic [CW-1:0]        count_r;
  logic signed [SW-1:0] sums_r [3];
  logic [SQW-1:0]       sqs_r [3];
  logic [31:0]          last_time_r;
  logic                 have_r;

  logic [34:0] acc_r;
  logic [7:0]  flags_r;

  // Serial multiplier.
  logic [PW-1:0]        ma_r, mp_r;
  logic [MB-1:0]        mb_r;
  logic [3:0]           mjob_r;
  logic                 busy_r;
  logic [MB-1:0]        ln_r;
  logic signed [VW-1:0] vxy_r, vz_r;

  logic [RW-1:0] rdata_r;
  logic [AW-1:0] tail;
  logic [CW:0]   tail_w;
  logic          ram_we;

  // Squarer.
  logic signed [16:0] sq_in;
  logic signed [33:0] sq_full;
  logic [32:0]        sq;

  always_comb begin
    case (cmd.sq_sel)
      SQ_QX:   sq_in = 17'(lane16({16'd0, quat_r}, LANE_X));
      SQ_QY:   sq_in = 17'(lane16({16'd0, quat_r}, LANE_Y));
      SQ_V:    sq_in = 17'(lane16(vel_r, cmd.lane));
      SQ_D:    sq_in = 17'(lane16(pos_r, cmd.lane)) - 17'(lane16(tgt_r, cmd.lane));
      SQ_SPD:  sq_in = $signed({1'b0, speed_lim_r});
      SQ_PEL:  sq_in = $signed({1'b0, pos_err_lim_r});
      SQ_IR:   sq_in = 17'(lane16(rates_r, cmd.lane));
      default: sq_in = 17'(lane16(rdata_r[79:32], cmd.lane));
    endcase
    sq_full = sq_in * sq_in;
    sq      = sq_full[32:0];
  end

  // Tilt: r22 = 1 - 2(x^2+y^2) at Q2.28, clamped below at -1.
  logic [34:0]        tsum;
  logic signed [36:0] r22, r22c, tlim;
  assign tsum = acc_r + 35'(sq);
  assign r22  = 37'sd268435456 - $signed({1'b0, tsum, 1'b0});
  assign r22c = (r22 < -37'sd268435456) ? -37'sd268435456 : r22;
  assign tlim = {{7{tilt_cos_r[15]}}, tilt_cos_r, 14'd0};

  logic signed [15:0] alt, amin, amax;
  assign alt  = lane16(pos_r, LANE_Z);
  assign amin = alt_bounds_r[15:0];
  assign amax = alt_bounds_r[31:16];

  // Oldest slot sits count entries behind the head.
  assign tail_w = (CW + 1)'(head_r) + (CW + 1)'(WINDOW_DEPTH) - {1'b0, count_r};
  assign tail   = (tail_w >= (CW + 1)'(WINDOW_DEPTH)) ?
                  AW'(tail_w - (CW + 1)'(WINDOW_DEPTH)) : AW'(tail_w);
  assign ram_we = (cmd.op == OP_INSERT) && (cmd.lane == LANE_X);

  fsem_ram #(.WIDTH(RW), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (head_r),
    .wdata   ({rates_r, t_r}),
    .raddr   (tail),
    .rdata_r (rdata_r)
  );

  assign sts.win_full  = (count_r == CW'(WINDOW_DEPTH));
  assign sts.win_empty = (count_r == '0);
  assign sts.age_over  = ((t_r - rdata_r[31:0]) > osc_window_r);
  assign sts.osc_en    = (count_r != '0) && (EW'(count_r) >= EW'(osc_min_r));
  assign sts.mul_busy  = busy_r;

  // Multiplier operands per job.
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MB-1:0] sabs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sabs[k] = sums_r[k][SW-1] ? MB'(-sums_r[k]) : MB'(sums_r[k]);
    end
    case (cmd.msel)
      MS_NQX:  begin mul_a = MA'(sqs_r[0]); mul_b = MB'(count_r); end
      MS_SX:   begin mul_a = MA'(sabs[0]);  mul_b = sabs[0]; end
      MS_NQY:  begin mul_a = MA'(sqs_r[1]); mul_b = MB'(count_r); end
      MS_SY:   begin mul_a = MA'(sabs[1]);  mul_b = sabs[1]; end
      MS_NQZ:  begin mul_a = MA'(sqs_r[2]); mul_b = MB'(count_r); end
      MS_SZ:   begin mul_a = MA'(sabs[2]);  mul_b = sabs[2]; end
      MS_LRPN: begin mul_a = MA'(osc_rms_r[15:0]); mul_b = MB'(count_r); end
      MS_LYWN: begin mul_a = MA'(osc_rms_r[31:16]); mul_b = MB'(count_r); end
      default: begin mul_a = MA'(ln_r); mul_b = ln_r; end
    endcase
  end

  logic signed [VW-1:0] prod_s;
  assign prod_s = $signed({1'b0, mp_r[VW-2:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_cos_r    <= -16'sd16384;
      speed_lim_r   <= 16'hFFFF;
      alt_bounds_r  <= 32'h7FFF8000;
      pos_err_lim_r <= 16'hFFFF;
      osc_window_r  <= 32'd1000;
      osc_min_r     <= 7'd10;
      osc_rms_r     <= 32'hFFFFFFFF;
      stale_to_r    <= 32'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILT_COS: tilt_cos_r    <= cfg_data[15:0];
        REG_SPEED:    speed_lim_r   <= cfg_data[15:0];
        REG_ALT:      alt_bounds_r  <= cfg_data;
        REG_POS_ERR:  pos_err_lim_r <= cfg_data[15:0];
        REG_OSC_WIN:  osc_window_r  <= cfg_data;
        REG_OSC_MIN:  osc_min_r     <= cfg_data[6:0];
        REG_OSC_RMS:  osc_rms_r     <= cfg_data;
        REG_STALE:    stale_to_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      t_r     <= in_tdata[31:0];
      quat_r  <= in_tdata[63:32];
      vel_r   <= in_tdata[111:64];
      pos_r   <= in_tdata[159:112];
      tgt_r   <= in_tdata[207:160];
      tv_r    <= in_tdata[208];
      mae_r   <= in_tdata[209];
      rates_r <= in_tdata[257:210];
    end
    if (cmd.load_out) begin
      out_flags_r <= flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      last_time_r <= '0;
      have_r      <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sums_r[k] <= '0;
        sqs_r[k]  <= '0;
      end
    end else begin
      case (cmd.op)
        OP_TILT: begin
          last_time_r <= t_r;
          have_r      <= 1'b1;
        end
        OP_EVICT: begin
          sums_r[cmd.lane] <= sums_r[cmd.lane] - SW'(lane16(rdata_r[79:32], cmd.lane));
          sqs_r[cmd.lane]  <= sqs_r[cmd.lane] - SQW'(sq);
          if (cmd.lane == LANE_Z) begin
            count_r <= count_r - CW'(1);
          end
        end
        OP_INSERT: begin
          sums_r[cmd.lane] <= sums_r[cmd.lane] + SW'(lane16(rates_r, cmd.lane));
          sqs_r[cmd.lane]  <= sqs_r[cmd.lane] + SQW'(sq);
          if (cmd.lane == LANE_Z) begin
            count_r <= count_r + CW'(1);
            head_r  <= (head_r == AW'(WINDOW_DEPTH - 1)) ? '0 : head_r + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Flags and the squared-magnitude accumulator.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      flags_r <= '0;
    end else begin
      case (cmd.op)
        OP_ACC_LOAD: acc_r <= 35'(sq);
        OP_ACC_ADD:  acc_r <= acc_r + 35'(sq);
        OP_TILT: begin
          flags_r[0] <= (r22c < tlim);
          flags_r[2] <= mae_r && (alt < amin);
          flags_r[3] <= (alt > amax);
        end
        OP_CMP_SPD: flags_r[1] <= (acc_r > 35'(sq));
        OP_CMP_POS: flags_r[4] <= tv_r && (acc_r > 35'(sq));
        OP_STALE:   flags_r[7] <= have_r && ((t_r - last_time_r) > stale_to_r);
        default: ;
      endcase
      if (busy_r && (mb_r == '0)) begin
        case (mjob_r)
          MS_LRPQ: flags_r[5] <= (vxy_r > prod_s);
          MS_LYWQ: flags_r[6] <= (vz_r > prod_s);
          default: ;
        endcase
      end
    end
  end

  // Shift-add multiplier, one multiplier bit a cycle, stops when no bits remain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (mb_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r   <= PW'(mul_a);
      mb_r   <= mul_b;
      mp_r   <= '0;
      mjob_r <= cmd.msel;
    end else if (busy_r) begin
      if (mb_r == '0) begin
        case (mjob_r)
          MS_NQX:  vxy_r <= prod_s;
          MS_SX:   vxy_r <= vxy_r - prod_s;
          MS_NQY:  vxy_r <= vxy_r + prod_s;
          MS_SY:   vxy_r <= vxy_r - prod_s;
          MS_NQZ:  vz_r  <= prod_s;
          MS_SZ:   vz_r  <= vz_r - prod_s;
          MS_LRPN: ln_r  <= mp_r[MB-1:0];
          MS_LYWN: ln_r  <= mp_r[MB-1:0];
          default: ;
        endcase
      end else begin
        mp_r <= mb_r[0] ? mp_r + ma_r : mp_r;
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end
    end
  end

endmodule

FILE: design/flight_safety_envelope_monitor_top.sv
// Channel | Direction | Word
// in      | slave     | tdata: odometry sample or query fields; tuser: kind
// out     | master    | tdata: eight flags
// cfg     | slave     | register index and 32-bit value, always ready
//
// A stale query passes the stale check and is loaded into the output register
// once it is free. A sample runs tilt, altitude, speed and position checks,
// drops the oldest window entry when the window is full, inserts its rates, then
// drops entries older than the oscillation window, and, when the oscillation
// check runs, forms ten serial products on a shift-add multiplier.
// Reset is synchronous; the window memory is not cleared.
// A new item is taken while the previous result waits on out_tready.
`include "flight_safety_envelope_monitor_top_assert.svh"

module flight_safety_envelope_monitor_top
  import fsem_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] time_ms, [63:32] quat_xy, [111:64] velocity, [159:112] position,
  // [207:160] target, [208] target_valid, [209] min_alt_enable,
  // [257:210] gyro rates, [263:258] zero
  input  logic [263:0] in_tdata,
  // [0] cmd
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] tilt_flag, [1] speed_flag, [2] alt_low_flag, [3] alt_high_flag,
  // [4] pos_error_flag, [5] osc_tilt_flag, [6] osc_yaw_flag, [7] stale_flag
  output logic [7:0]   out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  fsem_cmd_t cmd;
  fsem_sts_t sts;

  assign cfg_ready = 1'b1;

  fsem_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fsem_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_flags_r (out_tdata)
  );

  `FSEM_ASSERT_IMPL(a_stale_alone, out_tvalid && out_tdata[7], out_tdata[6:0] == 7'd0, "stale result carries sample flags")
  `FSEM_ASSERT_IMPL(a_idle_mul, in_tready, !sts.mul_busy, "multiplier busy while taking a word")
  `FSEM_ASSERT_IMPL(a_no_overfill, cmd.op == OP_INSERT, !sts.win_full, "insert into a full window")

endmodule
